// ===== hw/rtl/fbet_pkg.sv =====
`timescale 1ns / 1ps
package fbet_pkg;

	localparam int MAX_BUFFERS  = 4;
	localparam int MAX_PER_KIND = 32;

	// Register indexes of the configuration channel
	localparam logic [1:0] REG_DATA_PER_BLOCK = 2'd0;
	localparam logic [1:0] REG_FEC_PER_BLOCK  = 2'd1;
	localparam logic [1:0] REG_BUFFERS_IN_USE = 2'd2;

	// Result kinds
	localparam logic [1:0] RK_STATUS  = 2'd0;
	localparam logic [1:0] RK_PAIR    = 2'd1;
	localparam logic [1:0] RK_SUMMARY = 2'd2;

	// Store status codes
	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_KEPT   = 2'd1;
	localparam logic [1:0] ST_DROP   = 2'd2;

	typedef struct packed {
		logic [5:0] nd;
		logic [5:0] nf;
		logic [2:0] nb;
	} cfg_t;

	typedef struct packed {
		logic [31:0] blk;
		logic [5:0]  slot;
		logic        crc;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] blk;
		logic [1:0]  status;
		logic [4:0]  di;
		logic [4:0]  fi;
		logic [6:0]  lost;
		logic        fail;
		logic [31:0] mask;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
	typedef enum logic [2:0] {B_IDLE, B_EVAL, B_COUNT, B_PAIR, B_SUMM, B_STORE} back_state_t;

	// Saturate the raw register values
	function automatic cfg_t clamp_cfg(input logic [5:0] d, input logic [5:0] f,
			input logic [2:0] b);
		cfg_t c;
		c.nd = (d == 6'd0) ? 6'd1 : ((d > 6'd32) ? 6'd32 : d);
		c.nf = (f > 6'd32) ? 6'd32 : f;
		c.nb = (b == 3'd0) ? 3'd1 : ((b > 3'd4) ? 3'd4 : b);
		return c;
	endfunction

	// Slot of data packet k: interleaved while FEC lasts, then consecutive
	function automatic logic [5:0] data_slot(input logic [5:0] k, input logic [5:0] nf);
		logic [6:0] s;
		s = (k < nf) ? {k, 1'b0} : ({1'b0, k} + {1'b0, nf});
		return s[5:0];
	endfunction

	// Slot of FEC packet k
	function automatic logic [5:0] fec_slot(input logic [5:0] k, input logic [5:0] nd);
		logic [6:0] s;
		s = (k < nd) ? ({k, 1'b0} + 7'd1) : ({1'b0, k} + {1'b0, nd});
		return s[5:0];
	endfunction

endpackage

// ===== hw/rtl/fbet_front.sv =====
`timescale 1ns / 1ps
module fbet_front
	import fbet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_seq,
	input  logic        in_crc,
	output logic        push_valid,
	input  logic        push_ready,
	output cmd_t        push_cmd
);

	front_state_t state_q, state_d;
	logic [31:0] quot_q;
	logic [5:0]  rem_q;
	logic        crc_q;
	logic [4:0]  cnt_q;
	logic [6:0]  n;
	logic [6:0]  trial;
	logic        ge;
	logic [6:0]  rem_next;

	// One quotient bit per cycle
	assign n        = {1'b0, cfg.nd} + {1'b0, cfg.nf};
	assign trial    = {rem_q, quot_q[31]};
	assign ge       = (trial >= n);
	assign rem_next = ge ? (trial - n) : trial;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = F_DIV;
			end
			F_DIV: begin
				if (cnt_q == 5'd31) state_d = F_PUSH;
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= F_IDLE;
		else state_q <= state_d;
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			quot_q <= in_seq;
			rem_q  <= 6'd0;
			crc_q  <= in_crc;
			cnt_q  <= 5'd0;
		end else if (state_q == F_DIV) begin
			quot_q <= {quot_q[30:0], ge};
			rem_q  <= rem_next[5:0];
			cnt_q  <= cnt_q + 5'd1;
		end
	end

	assign push_cmd.blk  = quot_q;
	assign push_cmd.slot = rem_q;
	assign push_cmd.crc  = crc_q;

endmodule

// ===== hw/rtl/fbet_queue.sv =====
`timescale 1ns / 1ps
module fbet_queue
	import fbet_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd,
	output logic [1:0] level
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign level      = cnt_q;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== hw/rtl/fbet_back.sv =====
`timescale 1ns / 1ps
module fbet_back
	import fbet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  cmd_t        pop_cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_res,
	output logic        out_restart
);

	back_state_t state_q, state_d;

	logic signed [32:0] bbn_q [MAX_BUFFERS];
	logic [63:0]        rcv_q [MAX_BUFFERS];
	logic [63:0]        good_q [MAX_BUFFERS];
	logic signed [32:0] highest_q;

	cmd_t        cmd_q;
	logic        rs_q;
	logic [63:0] w_rcv_q, w_good_q;
	logic [31:0] old_q;
	logic [5:0]  k_q, di_q, fi_q;
	logic [5:0]  dmiss_q, fmiss_q;
	logic [31:0] rmask_q;

	logic        ovalid_q;
	res_t        ores_q;
	logic        orest_q;

	logic        out_free, emit;
	res_t        res_d;

	logic signed [33:0] blk_s, hi_s, span_s;
	logic        restart, evict, has_old;
	logic [1:0]  vic;
	logic [5:0]  kmax, ds, fs;
	logic        d_ok, f_rcv, pair_done;
	logic        k_d_rcv, k_f_rcv;
	logic        fail;
	logic [31:0] mask_all;
	logic        hit;
	logic [1:0]  hb;
	logic [63:0] sbit;

	assign out_free = !ovalid_q || out_ready;

	// Classify the packet against the window
	always_comb begin
		blk_s   = $signed({2'b00, cmd_q.blk});
		hi_s    = $signed({highest_q[32], highest_q});
		span_s  = $signed({24'd0, cfg.nb, 7'd0});
		restart = (blk_s + span_s) < hi_s;
		evict   = ((blk_s > hi_s) || restart) && cmd_q.crc;
		vic     = 2'd0;
		for (int b = 1; b < MAX_BUFFERS; b++) begin
			if (b < int'(cfg.nb) && bbn_q[b] < bbn_q[vic]) vic = 2'(b);
		end
		// A restart empties the window, so the first buffer takes the block
		if (restart) vic = 2'd0;
		has_old = evict && !restart && (bbn_q[vic] != -33'sd1);
	end

	// Per-step lookups of the finished block
	always_comb begin
		kmax      = (cfg.nd > cfg.nf) ? cfg.nd : cfg.nf;
		k_d_rcv   = (k_q < cfg.nd) && w_rcv_q[data_slot(k_q, cfg.nf)];
		k_f_rcv   = (k_q < cfg.nf) && w_rcv_q[fec_slot(k_q, cfg.nd)];
		ds        = data_slot(di_q, cfg.nf);
		fs        = fec_slot(fi_q, cfg.nd);
		d_ok      = w_rcv_q[ds] && w_good_q[ds];
		f_rcv     = w_rcv_q[fs];
		pair_done = (di_q >= cfg.nd) || (fi_q >= cfg.nf);
		fail      = dmiss_q > (cfg.nf - fmiss_q);
		mask_all  = 32'hFFFF_FFFF >> (6'd32 - cfg.nd);
	end

	// Find the buffer that holds the packet's block
	always_comb begin
		hit = 1'b0;
		hb  = 2'd0;
		for (int b = MAX_BUFFERS - 1; b >= 0; b--) begin
			if (b < int'(cfg.nb) && bbn_q[b] == $signed({1'b0, cmd_q.blk})) begin
				hit = 1'b1;
				hb  = 2'(b);
			end
		end
		sbit = 64'd1 << cmd_q.slot;
	end

	// Sequencer: next state and emitted result
	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		emit      = 1'b0;
		res_d     = '0;
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) state_d = B_EVAL;
			end
			B_EVAL: begin
				state_d = has_old ? B_COUNT : B_STORE;
			end
			B_COUNT: begin
				if (k_q + 6'd1 >= kmax) state_d = B_PAIR;
			end
			B_PAIR: begin
				if (pair_done) begin
					state_d = B_SUMM;
				end else if (!d_ok && f_rcv && out_free) begin
					emit     = 1'b1;
					res_d.kind = RK_PAIR;
					res_d.blk  = old_q;
					res_d.di   = di_q[4:0];
					res_d.fi   = fi_q[4:0];
				end
			end
			B_SUMM: begin
				if (out_free) begin
					emit       = 1'b1;
					res_d.kind = RK_SUMMARY;
					res_d.blk  = old_q;
					res_d.lost = {1'b0, dmiss_q} + {1'b0, fmiss_q};
					res_d.fail = fail;
					res_d.mask = fail ? rmask_q : mask_all;
					state_d    = B_STORE;
				end
			end
			B_STORE: begin
				if (out_free) begin
					emit         = 1'b1;
					res_d.kind   = RK_STATUS;
					res_d.blk    = cmd_q.blk;
					res_d.status = !hit ? ST_DROP : (good_q[hb][cmd_q.slot] ? ST_KEPT : ST_STORED);
					res_d.last   = 1'b1;
					state_d      = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	// Window state: evict, clear on restart, store marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < MAX_BUFFERS; b++) begin
				bbn_q[b]  <= -33'sd1;
				rcv_q[b]  <= '0;
				good_q[b] <= '0;
			end
			highest_q <= -33'sd1;
		end else if (state_q == B_EVAL && evict) begin
			// Claim the victim buffer; on a restart empty all others
			for (int b = 0; b < MAX_BUFFERS; b++) begin
				if (2'(b) == vic) begin
					bbn_q[b]  <= $signed({1'b0, cmd_q.blk});
					rcv_q[b]  <= '0;
					good_q[b] <= '0;
				end else if (restart) begin
					bbn_q[b]  <= -33'sd1;
					rcv_q[b]  <= '0;
					good_q[b] <= '0;
				end
			end
			highest_q   <= $signed({1'b0, cmd_q.blk});
		end else if (state_q == B_STORE && emit && hit && !good_q[hb][cmd_q.slot]) begin
			rcv_q[hb] <= rcv_q[hb] | sbit;
			if (cmd_q.crc) good_q[hb] <= good_q[hb] | sbit;
			else good_q[hb] <= good_q[hb] & ~sbit;
		end
	end

	// Working copy of the finished block and walk counters
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) cmd_q <= pop_cmd;
			end
			B_EVAL: begin
				rs_q     <= evict && restart;
				w_rcv_q  <= rcv_q[vic];
				w_good_q <= good_q[vic];
				old_q    <= bbn_q[vic][31:0];
				k_q      <= 6'd0;
				dmiss_q  <= 6'd0;
				fmiss_q  <= 6'd0;
				rmask_q  <= '0;
				di_q     <= 6'd0;
				fi_q     <= 6'd0;
			end
			B_COUNT: begin
				if (k_q < cfg.nd) begin
					if (k_d_rcv) rmask_q[k_q[4:0]] <= 1'b1;
					else dmiss_q <= dmiss_q + 6'd1;
				end
				if (k_q < cfg.nf && !k_f_rcv) fmiss_q <= fmiss_q + 6'd1;
				k_q <= k_q + 6'd1;
			end
			B_PAIR: begin
				if (!pair_done) begin
					if (d_ok) di_q <= di_q + 6'd1;
					else if (!f_rcv) fi_q <= fi_q + 6'd1;
					else if (out_free) begin
						di_q <= di_q + 6'd1;
						fi_q <= fi_q + 6'd1;
					end
				end
			end
			B_SUMM, B_STORE: ;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (emit) ovalid_q <= 1'b1;
		else if (out_ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ores_q  <= res_d;
			orest_q <= rs_q;
		end
	end

	assign out_valid   = ovalid_q;
	assign out_res     = ores_q;
	assign out_restart = orest_q;

endmodule

// ===== hw/rtl/fec_block_erasure_tracker_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake           | Payload
// s_       | in  | s_tvalid/s_tready   | tdata: packet sequence; tuser: crc_ok
// m_       | out | m_tvalid/m_tready   | tdata: result fields; tuser: kind; tlast
// cfg_     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The front takes one header at a time: it accepts it, divides it bit-serially
// by the data+FEC count and pushes the result to the queue. The back takes a
// packet that finishes no block through accept, evaluate and store; a finished
// block adds miss counting over its data and FEC slots, a repair walk and summary.
// Reset clears the window at once; no clearing pass. Either side may stall.
module fec_block_erasure_tracker_unit
	import fbet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] packet sequence
	input  logic        s_tuser,   // [0] crc_ok
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [31:0] block_number, [33:32] store_status,
	                               // [38:34] data_index, [43:39] fec_index,
	                               // [50:44] lost_count, [51] repair_failed,
	                               // [83:52] deliver_mask, [84] restart_seen, zero pad
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	logic [5:0] data_per_block_q;
	logic [5:0] fec_per_block_q;
	logic [2:0] buffers_in_use_q;
	cfg_t       cfg;

	logic push_valid, push_ready, pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;
	logic [1:0] q_level;
	res_t res;
	logic restart;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_per_block_q <= 6'd8;
			fec_per_block_q  <= 6'd4;
			buffers_in_use_q <= 3'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DATA_PER_BLOCK: data_per_block_q <= cfg_data;
				REG_FEC_PER_BLOCK:  fec_per_block_q  <= cfg_data;
				REG_BUFFERS_IN_USE: buffers_in_use_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = clamp_cfg(data_per_block_q, fec_per_block_q, buffers_in_use_q);

	fbet_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_seq     (s_tdata),
		.in_crc     (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	fbet_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.level      (q_level)
	);

	fbet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_cmd     (pop_cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res),
		.out_restart (restart)
	);

	assign m_tdata = {3'd0, restart, res.mask, res.fail, res.lost, res.fi, res.di,
		res.status, res.blk};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

	// Only the store status result closes an item
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == RK_STATUS)))
		else $error("tlast does not match status result");

	// Queue never overfills
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level != 2'd3)
		else $error("queue level out of range");

	// Summary loses at most all slots of a block
	a_lost_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == RK_SUMMARY) |-> (m_tdata[50:44] <= 7'd64))
		else $error("lost count out of range");

	// Front pushes only after a full division
	a_push_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !$past(push_valid)) |-> !$past(s_tready))
		else $error("push without division");

endmodule

// ===== verif/fbet_checker.sv =====
`timescale 1ns / 1ps
module fbet_checker
	import fbet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [87:0] payload;
		logic        last;
	} outcome_t;

	outcome_t    outcomes[$];
	logic [5:0]  reg_nd, reg_nf;
	logic [2:0]  reg_nb;
	longint      win_blk[MAX_BUFFERS];
	logic [63:0] win_rcv[MAX_BUFFERS];
	logic [63:0] win_good[MAX_BUFFERS];
	longint      top_blk;

	assign pending = outcomes.size();

	function automatic outcome_t make_outcome(logic [1:0] kind, logic [31:0] blk,
			logic [1:0] st, logic [4:0] di, logic [4:0] fi, logic [6:0] lost,
			logic fail, logic [31:0] mask, logic rs, logic last);
		outcome_t o;
		o.kind = kind;
		o.payload = {3'b0, rs, mask, fail, lost, fi, di, st, blk};
		o.last = last;
		return o;
	endfunction

	// Track the window for one packet header and queue the results it causes
	task automatic track_packet(input logic [31:0] seq, input logic crc);
		int unsigned nd, nf, nb, n, slot, victim, di, fi, s, dmiss, fmiss;
		int unsigned dslot[MAX_PER_KIND];
		int unsigned fslot[MAX_PER_KIND];
		longint blk, old;
		logic restart;
		logic [63:0] rcv, good;
		logic [31:0] mask;
		logic fail;
		logic [1:0] st;
		nd = (reg_nd == 0) ? 1 : ((reg_nd > MAX_PER_KIND) ? MAX_PER_KIND : reg_nd);
		nf = (reg_nf > MAX_PER_KIND) ? MAX_PER_KIND : reg_nf;
		nb = (reg_nb == 0) ? 1 : ((reg_nb > MAX_BUFFERS) ? MAX_BUFFERS : reg_nb);
		n = nd + nf;
		blk = longint'(seq / n);
		slot = seq % n;
		restart = (blk + 128 * longint'(nb)) < top_blk;
		if ((blk > top_blk || restart) && crc) begin
			// Clear the whole window on a transmitter restart
			if (restart) begin
				for (int b = 0; b < MAX_BUFFERS; b++) begin
					win_blk[b] = -1;
					win_rcv[b] = '0;
					win_good[b] = '0;
				end
			end
			victim = 0;
			for (int b = 1; b < nb; b++)
				if (win_blk[b] < win_blk[victim]) victim = b;
			old = win_blk[victim];
			if (old != -1) begin
				rcv = win_rcv[victim];
				good = win_good[victim];
				di = 0; fi = 0; s = 0; dmiss = 0; fmiss = 0; mask = '0;
				while (di < nd || fi < nf) begin
					if (di < nd) begin
						dslot[di] = s;
						if (!rcv[s]) dmiss++;
						s++; di++;
					end
					if (fi < nf) begin
						fslot[fi] = s;
						if (!rcv[s]) fmiss++;
						s++; fi++;
					end
				end
				fail = dmiss > (nf - fmiss);
				// Walk bad data slots against received FEC slots
				di = 0; fi = 0;
				while (di < nd && fi < nf) begin
					if (rcv[dslot[di]] && good[dslot[di]]) di++;
					else if (!rcv[fslot[fi]]) fi++;
					else begin
						outcomes.push_back(make_outcome(RK_PAIR, old[31:0], ST_STORED,
							di[4:0], fi[4:0], '0, 1'b0, '0, restart, 1'b0));
						di++; fi++;
					end
				end
				for (int i = 0; i < nd; i++)
					if (!fail || rcv[dslot[i]]) mask[i] = 1'b1;
				outcomes.push_back(make_outcome(RK_SUMMARY, old[31:0], ST_STORED, '0, '0,
					7'(dmiss + fmiss), fail, mask, restart, 1'b0));
				win_rcv[victim] = '0;
				win_good[victim] = '0;
			end
			win_blk[victim] = blk;
			top_blk = blk;
		end
		// Store the packet marks if its block is in the window
		st = ST_DROP;
		for (int b = 0; b < nb; b++) begin
			if (win_blk[b] == blk) begin
				if (win_good[b][slot]) st = ST_KEPT;
				else begin
					win_rcv[b][slot] = 1'b1;
					win_good[b][slot] = crc;
					st = ST_STORED;
				end
				break;
			end
		end
		outcomes.push_back(make_outcome(RK_STATUS, blk[31:0], st, '0, '0, '0, 1'b0, '0,
			restart && crc, 1'b1));
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o;
		if (!arst_n) begin
			reg_nd <= 6'd8;
			reg_nf <= 6'd4;
			reg_nb <= 3'd1;
			for (int b = 0; b < MAX_BUFFERS; b++) begin
				win_blk[b] = -1;
				win_rcv[b] = '0;
				win_good[b] = '0;
			end
			top_blk = -1;
			fail_count <= 0;
			outcomes.delete();
		end else begin
			// Apply register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DATA_PER_BLOCK: reg_nd <= cfg_data;
					REG_FEC_PER_BLOCK:  reg_nf <= cfg_data;
					REG_BUFFERS_IN_USE: reg_nb <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				track_packet(s_tdata, s_tuser);
			// Compare each result transaction with the oldest expectation
			if (m_tvalid && m_tready) begin
				if (outcomes.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind=%0d data=%h",
						$time, m_tuser, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_o = outcomes.pop_front();
					if (exp_o.kind !== m_tuser || exp_o.payload !== m_tdata
							|| exp_o.last !== m_tlast) begin
						$display("%0t: mismatch expected kind=%0d data=%h last=%b",
							$time, exp_o.kind, exp_o.payload, exp_o.last);
						$display("%0t:          actual kind=%0d data=%h last=%b",
							$time, m_tuser, m_tdata, m_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb
	import fbet_pkg::*;
();

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [31:0] s_tdata;
	logic        m_tvalid, m_tready, m_tlast;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;
	int          fail_count, pending;
	int          cycles;
	int          stall_mode;
	logic [31:0] base_seq;
	logic [6:0]  cur_n;

	fec_block_erasure_tracker_unit i_dut (.*);

	fbet_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bound the run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("** fec_block_erasure_tracker_unit: FAILED **");
				$finish;
			end
		end
	end

	// Receiver stalls on a pattern that changes mode now and then
	initial begin
		m_tready = 1'b0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (cycles % 7) < 4;
			endcase
		end
	end

	// Hold one register write until accepted; the caller drops valid
	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Wait until every expected result has arrived and the back end is idle
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic configure(input logic [5:0] nd, input logic [5:0] nf,
			input logic [2:0] nb);
		drain();
		write_reg(REG_DATA_PER_BLOCK, nd);
		write_reg(REG_FEC_PER_BLOCK, nf);
		write_reg(REG_BUFFERS_IN_USE, {3'b0, nb});
		cfg_valid <= 1'b0;
		cur_n = {1'b0, (nd == 6'd0) ? 6'd1 : ((nd > 6'd32) ? 6'd32 : nd)}
			+ {1'b0, (nf > 6'd32) ? 6'd32 : nf};
	endtask

	// Send one header, sometimes after a random gap
	task automatic send_header(input logic [31:0] seq, input logic crc);
		if ($urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= seq;
		s_tuser <= crc;
		do @(posedge clk); while (!s_tready);
	endtask

	// A run of packets over a few consecutive blocks with random losses
	task automatic send_blocks(input int nblk, input int loss_pct);
		for (int b = 0; b < nblk; b++) begin
			for (int k = 0; k < cur_n; k++) begin
				if ($urandom_range(0, 99) >= loss_pct)
					send_header(base_seq + b * cur_n + k, $urandom_range(0, 9) != 0);
				if ($urandom_range(0, 15) == 0)
					send_header(base_seq + b * cur_n + $urandom_range(0, cur_n - 1),
						1'($urandom_range(0, 1)));
			end
		end
		s_tvalid <= 1'b0;
		base_seq = base_seq + nblk * cur_n;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DATA_PER_BLOCK;
		cfg_data = '0;
		cur_n = 7'd12;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset sizes, extremes, duplicates, bad CRC, restart
		base_seq = 0;
		send_header(32'd0, 1'b1);
		send_header(32'd0, 1'b1);
		send_header(32'd1, 1'b0);
		send_header(32'd3, 1'b0);
		send_header(32'd3, 1'b1);
		send_header(32'd40, 1'b0);
		send_header(32'd13, 1'b1);
		send_header(32'hFFFF_FFFF, 1'b1);
		send_header(32'hFFFF_FFF0, 1'b0);
		send_header(32'd5, 1'b1);
		send_header(32'd5, 1'b1);
		send_header(32'hAAAA_AAAA, 1'b1);
		send_header(32'h5555_5555, 1'b1);
		s_tvalid <= 1'b0;

		configure(6'd0, 6'd0, 3'd0);
		send_header(32'd0, 1'b1);
		send_header(32'd1, 1'b1);
		send_header(32'd3, 1'b0);
		send_header(32'd2, 1'b1);
		s_tvalid <= 1'b0;

		configure(6'd63, 6'd63, 3'd7);
		base_seq = 0;
		send_blocks(1, 10);
		send_header(32'd10000, 1'b1);
		send_header(32'd64, 1'b1);
		s_tvalid <= 1'b0;

		// Random phases over several settings, mostly well-formed block runs
		for (int ph = 0; ph < 10; ph++) begin
			configure(6'($urandom_range(1, 10)), 6'($urandom_range(0, 6)),
				3'($urandom_range(1, 4)));
			if (ph == 3) configure(6'd32, 6'd32, 3'd4);
			if (ph == 4) configure(6'd1, 6'd0, 3'd1);
			if (ph == 5) configure(6'd32, 6'd0, 3'd2);
			if (ph == 6) configure(6'd1, 6'd32, 3'd3);
			base_seq = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 5000);
			send_blocks($urandom_range(1, 2), $urandom_range(0, 40));
			// Noise, reordering, and a restart to an old sequence
			repeat (6) send_header($urandom(), 1'($urandom_range(0, 1)));
			send_header(base_seq - cur_n * $urandom_range(1, 3), 1'($urandom_range(0, 1)));
			send_header($urandom_range(0, 100), 1'b1);
			s_tvalid <= 1'b0;
			base_seq = $urandom_range(200, 900);
			send_blocks(1, 20);
		end

		drain();
		if (fail_count == 0)
			$display("** fec_block_erasure_tracker_unit: PASSED **");
		else
			$display("** fec_block_erasure_tracker_unit: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/fbet_pkg.sv
hw/rtl/fbet_front.sv
hw/rtl/fbet_queue.sv
hw/rtl/fbet_back.sv
hw/rtl/fec_block_erasure_tracker_unit.sv
verif/fbet_checker.sv
verif/tb.sv
